[rtl/boae_pkg.sv]
// ----------------------------------------------------------------------------
// boae_pkg
// Shared types and constants for the bounded ordered array engine.
// ----------------------------------------------------------------------------
package boae_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CMD_W     = 3;
	localparam int POS_W     = 5;
	localparam int DATA_W    = 32;
	localparam int STAT_W    = 2;
	localparam int FOUND_W   = 4;
	localparam int CNT_W     = 5;
	localparam int MAX_ROWS  = (1 << CNT_W) - 1;

	localparam logic [CNT_W-1:0] CAPACITY_RST = CNT_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND    = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_DELETE    = 3'd2,
		CMD_SEARCH    = 3'd3,
		CMD_OVERWRITE = 3'd4,
		CMD_READ      = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_POS   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ENC
	} state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic load_out;
	} ctrl_cmd_t;

endpackage

[rtl/boae_ctrl.sv]
// ----------------------------------------------------------------------------
// boae_ctrl
// Sequencer: capture an item, execute it on the register row, encode the
// result into the output register, and run the output valid flag.
// ----------------------------------------------------------------------------
module boae_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output boae_pkg::ctrl_cmd_t   ctl
);

	boae_pkg::state_t state_q;
	boae_pkg::state_t state_d;
	logic             out_valid_q;
	logic             out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= boae_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl.load_in  = 1'b0;
		ctl.exec     = 1'b0;
		ctl.load_out = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			boae_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_d     = boae_pkg::ST_EXEC;
				end
			end
			boae_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = boae_pkg::ST_ENC;
			end
			boae_pkg::ST_ENC: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = boae_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = boae_pkg::ST_IDLE;
			end
		endcase
		if (ctl.load_out)
			out_valid_d = 1'b1;
		else if (out_ready)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == boae_pkg::ST_EXEC)
		else $error("accepted item did not move to execute");

	a_exec_to_enc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == boae_pkg::ST_EXEC |=> state_q == boae_pkg::ST_ENC)
		else $error("execute not followed by encode");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !out_valid_q || out_ready)
		else $error("result overwritten before it was taken");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == boae_pkg::ST_ENC)
		else $error("output valid raised outside encode");

endmodule

[rtl/boae_dp.sv]
// ----------------------------------------------------------------------------
// boae_dp
// Datapath: capacity register, entry count, register row with neighbor
// shifts, parallel compare, lowest-match encoder and the output register.
// ----------------------------------------------------------------------------
module boae_dp #(
	parameter int DEPTH = boae_pkg::DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  boae_pkg::ctrl_cmd_t                    ctl,
	input  logic                                   cfg_we,
	input  logic        [boae_pkg::CNT_W-1:0]      cfg_wdata,
	input  logic        [boae_pkg::CMD_W-1:0]      cmd,
	input  logic        [boae_pkg::POS_W-1:0]      position,
	input  logic signed [boae_pkg::DATA_W-1:0]     value,
	output logic        [boae_pkg::STAT_W-1:0]     status,
	output logic signed [boae_pkg::DATA_W-1:0]     read_value,
	output logic        [boae_pkg::FOUND_W-1:0]    found_position,
	output logic        [boae_pkg::CNT_W-1:0]      entry_count
);

	localparam int CW   = boae_pkg::CNT_W;
	localparam int DW   = boae_pkg::DATA_W;
	localparam int FW   = boae_pkg::FOUND_W;
	localparam int ROWS = (DEPTH < boae_pkg::MAX_ROWS) ? DEPTH : boae_pkg::MAX_ROWS;
	localparam int IW   = $clog2(ROWS);

	logic [CW-1:0]                capacity_q;
	logic [CW-1:0]                count_q;
	logic [boae_pkg::CMD_W-1:0]   cmd_s1;
	logic [boae_pkg::POS_W-1:0]   pos_s1;
	logic [DW-1:0]                val_s1;
	logic [DW-1:0]                store_q [ROWS];
	logic [DW-1:0]                store_d [ROWS];

	logic [boae_pkg::STAT_W-1:0]  stat_s2;
	logic [DW-1:0]                rd_s2;
	logic [ROWS-1:0]              match_s2;
	logic                         srch_s2;

	logic [boae_pkg::STAT_W-1:0]  stat_q;
	logic [DW-1:0]                rdv_q;
	logic [FW-1:0]                found_q;
	logic [CW-1:0]                ecount_q;

	logic [CW-1:0]                lim;
	logic                         full;
	logic                         pos_in;
	logic                         pos_le;
	logic                         do_app;
	logic                         do_ins;
	logic                         do_del;
	logic                         do_ovw;
	logic [CW-1:0]                count_d;
	logic [boae_pkg::STAT_W-1:0]  exec_stat;
	logic [DW-1:0]                exec_rd;
	logic [ROWS-1:0]              match;
	logic [ROWS-1:0]              low_bit;
	logic [IW-1:0]                low_idx;
	logic [boae_pkg::STAT_W-1:0]  out_stat;
	logic [FW-1:0]                out_found;

	assign lim    = (capacity_q < CW'(ROWS)) ? capacity_q : CW'(ROWS);
	assign full   = count_q >= lim;
	assign pos_in = pos_s1 < count_q;
	assign pos_le = pos_s1 <= count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= boae_pkg::CAPACITY_RST;
			count_q    <= '0;
		end else begin
			if (cfg_we)
				capacity_q <= cfg_wdata;
			if (ctl.exec)
				count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_s1 <= cmd;
			pos_s1 <= position;
			val_s1 <= value;
		end
	end

	always_comb begin
		do_app    = 1'b0;
		do_ins    = 1'b0;
		do_del    = 1'b0;
		do_ovw    = 1'b0;
		exec_stat = boae_pkg::STAT_OK;
		exec_rd   = '0;
		count_d   = count_q;
		unique case (cmd_s1)
			boae_pkg::CMD_APPEND: begin
				if (full) begin
					exec_stat = boae_pkg::STAT_FULL;
				end else begin
					do_app  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			boae_pkg::CMD_INSERT: begin
				if (!pos_le) begin
					exec_stat = boae_pkg::STAT_BAD_POS;
				end else if (full) begin
					exec_stat = boae_pkg::STAT_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			boae_pkg::CMD_DELETE: begin
				if (!pos_in) begin
					exec_stat = boae_pkg::STAT_BAD_POS;
				end else begin
					do_del  = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			boae_pkg::CMD_SEARCH: begin
				exec_stat = boae_pkg::STAT_NOT_FOUND;
			end
			boae_pkg::CMD_OVERWRITE: begin
				if (!pos_in)
					exec_stat = boae_pkg::STAT_BAD_POS;
				else
					do_ovw = 1'b1;
			end
			boae_pkg::CMD_READ: begin
				if (!pos_in)
					exec_stat = boae_pkg::STAT_BAD_POS;
				else
					exec_rd = store_q[pos_s1[IW-1:0]];
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < ROWS; i++) begin : g_row
		logic [DW-1:0] up_src;
		logic [DW-1:0] dn_src;

		if (i > 0) begin : g_up
			assign up_src = store_q[i-1];
		end else begin : g_up0
			assign up_src = store_q[i];
		end

		if (i < ROWS - 1) begin : g_dn
			assign dn_src = store_q[i+1];
		end else begin : g_dnl
			assign dn_src = store_q[i];
		end

		always_comb begin
			store_d[i] = store_q[i];
			if (do_app && count_q == CW'(i))
				store_d[i] = val_s1;
			if (do_ins) begin
				if (pos_s1 == CW'(i))
					store_d[i] = val_s1;
				else if (pos_s1 < CW'(i) && CW'(i) <= count_q)
					store_d[i] = up_src;
			end
			if (do_del && pos_s1 <= CW'(i) && CW'(i + 1) < count_q)
				store_d[i] = dn_src;
			if (do_ovw && pos_s1 == CW'(i))
				store_d[i] = val_s1;
		end

		assign match[i] = (store_q[i] == val_s1) && (CW'(i) < count_q);

		always_ff @(posedge clk) begin
			if (ctl.exec)
				store_q[i] <= store_d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			stat_s2  <= exec_stat;
			rd_s2    <= exec_rd;
			match_s2 <= match;
			srch_s2  <= (cmd_s1 == boae_pkg::CMD_SEARCH);
		end
	end

	// isolate the lowest match, then encode it
	assign low_bit = match_s2 & (~match_s2 + ROWS'(1));

	always_comb begin
		low_idx = '0;
		for (int k = 0; k < ROWS; k++) begin
			if (low_bit[k])
				low_idx = low_idx | IW'(k);
		end
		if (srch_s2 && |match_s2) begin
			out_stat  = boae_pkg::STAT_OK;
			out_found = FW'(low_idx);
		end else begin
			out_stat  = stat_s2;
			out_found = '0;
		end
		if (srch_s2 && !(|match_s2))
			out_stat = boae_pkg::STAT_NOT_FOUND;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			stat_q   <= out_stat;
			rdv_q    <= rd_s2;
			found_q  <= out_found;
			ecount_q <= count_q;
		end
	end

	assign status         = stat_q;
	assign read_value     = rdv_q;
	assign found_position = found_q;
	assign entry_count    = ecount_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> count_q <= CW'(ROWS))
		else $error("entry count beyond row count");

endmodule

[rtl/bounded_ordered_array_engine_core.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_array_engine_core
// Packed list of signed words with append, insert, delete, search,
// overwrite and read commands, bounded by a capacity register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: cmd,
//   position, value. Output channel (out_valid/out_ready) returns one
//   result item per command: status, read_value, found_position and
//   entry_count after the command.
//   cfg_we/cfg_wdata write the capacity register; write it only while idle.
//   Each item passes through capture on the accepting edge, execute
//   on the register row (all shifts and all compares in parallel), then
//   lowest-match encode into the output register. One item is in flight
//   at a time, so a new item is taken only once the last is encoded;
//   out_valid rises after the execute and encode steps.
//   The output register holds a finished result while the next item is
//   taken; if the receiver stalls, the engine waits in the encode step
//   until the result register is free, and in_ready stays low meanwhile.
//   Reset clears the entry count to zero, sets capacity to 16 and drops
//   out_valid. Entry contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module bounded_ordered_array_engine_core #(
	parameter int DEPTH = boae_pkg::DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic        [boae_pkg::CMD_W-1:0]      cmd,
	input  logic        [boae_pkg::POS_W-1:0]      position,
	input  logic signed [boae_pkg::DATA_W-1:0]     value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic        [boae_pkg::STAT_W-1:0]     status,
	output logic signed [boae_pkg::DATA_W-1:0]     read_value,
	output logic        [boae_pkg::FOUND_W-1:0]    found_position,
	output logic        [boae_pkg::CNT_W-1:0]      entry_count,
	input  logic                                   cfg_we,
	input  logic        [boae_pkg::CNT_W-1:0]      cfg_wdata
);

	boae_pkg::ctrl_cmd_t ctl;

	boae_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	boae_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.position       (position),
		.value          (value),
		.status         (status),
		.read_value     (read_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

endmodule

[test/bounded_ordered_array_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_array_engine_core_tb
// Self-checking bench for the bounded ordered array engine. A tracker keeps
// its own copy of the packed list, count and capacity, works out the result
// of each accepted command and checks every returned result in order.
// Directed commands hit empty, full and out-of-range cases, then random
// phases at several capacities fill and drain the list under random idling
// on both channels and two long receiver stalls.
// ----------------------------------------------------------------------------
module bounded_ordered_array_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int LONG_HOLD    = 60;
	localparam int HOLD_AT_ITEM = 120;

	localparam logic [boae_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [boae_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct {
		boae_pkg::status_t                  status;
		logic signed [boae_pkg::DATA_W-1:0] read_value;
		logic [boae_pkg::FOUND_W-1:0]       found_position;
		logic [boae_pkg::CNT_W-1:0]         entry_count;
	} list_result_t;

	class ordered_list_tracker;
		logic signed [boae_pkg::DATA_W-1:0] words [boae_pkg::DEPTH_DEF];
		int                                 count;
		int                                 capacity;
		int                                 errors;
		int                                 checked;
		int                                 status_seen [4];
		list_result_t                       awaited_results [$];

		function void clear();
			foreach (words[i]) words[i] = '0;
			count    = 0;
			capacity = int'(boae_pkg::CAPACITY_RST);
			errors   = 0;
			checked  = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			awaited_results.delete();
		endfunction

		function int limit();
			return (capacity < boae_pkg::DEPTH_DEF) ? capacity : boae_pkg::DEPTH_DEF;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void note_command(logic [boae_pkg::CMD_W-1:0] c,
				logic [boae_pkg::POS_W-1:0] p, logic signed [boae_pkg::DATA_W-1:0] v);
			list_result_t r;
			int           i;
			r.status         = boae_pkg::STAT_OK;
			r.read_value     = '0;
			r.found_position = '0;
			case (c)
				boae_pkg::CMD_APPEND: begin
					if (count >= limit()) begin
						r.status = boae_pkg::STAT_FULL;
					end else begin
						words[count] = v;
						count++;
					end
				end
				boae_pkg::CMD_INSERT: begin
					if (int'(p) > count) begin
						r.status = boae_pkg::STAT_BAD_POS;
					end else if (count >= limit()) begin
						r.status = boae_pkg::STAT_FULL;
					end else begin
						for (i = count; i > int'(p); i--) words[i] = words[i-1];
						words[p] = v;
						count++;
					end
				end
				boae_pkg::CMD_DELETE: begin
					if (int'(p) >= count) begin
						r.status = boae_pkg::STAT_BAD_POS;
					end else begin
						for (i = int'(p); i + 1 < count; i++) words[i] = words[i+1];
						count--;
					end
				end
				boae_pkg::CMD_SEARCH: begin
					r.status = boae_pkg::STAT_NOT_FOUND;
					for (i = 0; i < count; i++) begin
						if (words[i] == v) begin
							r.status         = boae_pkg::STAT_OK;
							r.found_position = i[boae_pkg::FOUND_W-1:0];
							break;
						end
					end
				end
				boae_pkg::CMD_OVERWRITE: begin
					if (int'(p) >= count) r.status = boae_pkg::STAT_BAD_POS;
					else words[p] = v;
				end
				boae_pkg::CMD_READ: begin
					if (int'(p) >= count) r.status = boae_pkg::STAT_BAD_POS;
					else r.read_value = words[p];
				end
				default: ;
			endcase
			r.entry_count = count[boae_pkg::CNT_W-1:0];
			awaited_results.push_back(r);
		endfunction

		function void check_result(logic [boae_pkg::STAT_W-1:0] st,
				logic signed [boae_pkg::DATA_W-1:0] rd,
				logic [boae_pkg::FOUND_W-1:0] fp, logic [boae_pkg::CNT_W-1:0] cnt);
			list_result_t r;
			if (awaited_results.size() == 0) begin
				$error("result item arrived with no command outstanding");
				errors++;
				return;
			end
			r = awaited_results.pop_front();
			checked++;
			status_seen[r.status]++;
			if (st !== r.status) begin
				$error("status: expected %0d, actual %0d", r.status, st);
				errors++;
			end
			if (rd !== r.read_value) begin
				$error("read_value: expected %0d, actual %0d", r.read_value, rd);
				errors++;
			end
			if (fp !== r.found_position) begin
				$error("found_position: expected %0d, actual %0d", r.found_position, fp);
				errors++;
			end
			if (cnt !== r.entry_count) begin
				$error("entry_count: expected %0d, actual %0d", r.entry_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [boae_pkg::CMD_W-1:0]         cmd;
	logic [boae_pkg::POS_W-1:0]         position;
	logic signed [boae_pkg::DATA_W-1:0] value;
	logic                               out_valid;
	logic                               out_ready;
	logic [boae_pkg::STAT_W-1:0]        status;
	logic signed [boae_pkg::DATA_W-1:0] read_value;
	logic [boae_pkg::FOUND_W-1:0]       found_position;
	logic [boae_pkg::CNT_W-1:0]         entry_count;
	logic                               cfg_we;
	logic [boae_pkg::CNT_W-1:0]         cfg_wdata;

	ordered_list_tracker list_track;
	int                  send_idle_pct;
	int                  recv_idle_pct;
	int                  commands_sent;
	int                  capacity_writes;
	bit                  hold_trigger;
	bit                  growing;

	bounded_ordered_array_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.position      (position),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.read_value    (read_value),
		.found_position(found_position),
		.entry_count   (entry_count),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_command(input logic [boae_pkg::CMD_W-1:0] c,
			input logic [boae_pkg::POS_W-1:0] p,
			input logic signed [boae_pkg::DATA_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		position <= p;
		value    <= v;
		do begin
			@(posedge clk);
		end while (!in_ready);
		list_track.note_command(c, p, v);
		commands_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (list_track.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input int cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap[boae_pkg::CNT_W-1:0];
		@(posedge clk);
		list_track.capacity = cap;
		capacity_writes++;
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [boae_pkg::DATA_W-1:0] pick_word();
		case ($urandom_range(9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return -32'sd1;
			3:       return 32'sd0;
			4:       return $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	task automatic make_command(output logic [boae_pkg::CMD_W-1:0] c,
			output logic [boae_pkg::POS_W-1:0] p,
			output logic signed [boae_pkg::DATA_W-1:0] v);
		int n;
		int r;
		n = list_track.count;
		if (n == 0) growing = 1'b1;
		else if (n >= list_track.limit()) growing = 1'b0;
		else if ($urandom_range(99) == 0) growing = !growing;
		if ($urandom_range(99) < 5) begin
			c = boae_pkg::CMD_W'($urandom_range(7));
			p = boae_pkg::POS_W'($urandom_range(31));
			v = $urandom;
			return;
		end
		r = $urandom_range(99);
		if (growing) begin
			if (r < 25)      c = boae_pkg::CMD_APPEND;
			else if (r < 45) c = boae_pkg::CMD_INSERT;
			else if (r < 55) c = boae_pkg::CMD_DELETE;
			else if (r < 72) c = boae_pkg::CMD_SEARCH;
			else if (r < 86) c = boae_pkg::CMD_OVERWRITE;
			else             c = boae_pkg::CMD_READ;
		end else begin
			if (r < 8)       c = boae_pkg::CMD_APPEND;
			else if (r < 16) c = boae_pkg::CMD_INSERT;
			else if (r < 50) c = boae_pkg::CMD_DELETE;
			else if (r < 70) c = boae_pkg::CMD_SEARCH;
			else if (r < 85) c = boae_pkg::CMD_OVERWRITE;
			else             c = boae_pkg::CMD_READ;
		end
		v = pick_word();
		if (c == boae_pkg::CMD_SEARCH && n > 0 && $urandom_range(99) < 70)
			v = list_track.words[$urandom_range(n - 1)];
		if ($urandom_range(99) < 12)
			p = boae_pkg::POS_W'($urandom_range(31));
		else if (c == boae_pkg::CMD_INSERT)
			p = boae_pkg::POS_W'($urandom_range(n));
		else
			p = (n > 0) ? boae_pkg::POS_W'($urandom_range(n - 1)) : '0;
	endtask

	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int hold_left;
			@(posedge clk);
			if (out_valid && out_ready)
				list_track.check_result(status, read_value, found_position, entry_count);
			if (hold_trigger) begin
				hold_trigger = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		int                                 caps [PHASES];
		logic [boae_pkg::CMD_W-1:0]         c;
		logic [boae_pkg::POS_W-1:0]         p;
		logic signed [boae_pkg::DATA_W-1:0] v;
		list_track      = new();
		list_track.clear();
		send_idle_pct   = 31;
		recv_idle_pct   = 84;
		commands_sent   = 0;
		capacity_writes = 0;
		hold_trigger    = 1'b0;
		growing         = 1'b1;
		caps            = '{16, 1, 5, 0, 31, 3, 16, 8};
		caps[7]         = int'($urandom_range(2, 15));
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= '0;
		position  <= '0;
		value     <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(boae_pkg::CMD_READ, 5'd0, 32'sd5);
		send_command(boae_pkg::CMD_DELETE, 5'd0, 32'sd0);
		send_command(boae_pkg::CMD_SEARCH, 5'd0, 32'sd0);
		send_command(boae_pkg::CMD_OVERWRITE, 5'd0, 32'sd9);
		send_command(CMD_SPARE_LO, 5'd31, -32'sd1);
		send_command(CMD_SPARE_HI, 5'd0, 32'sd0);
		send_command(boae_pkg::CMD_INSERT, 5'd1, 32'sd1);
		send_command(boae_pkg::CMD_INSERT, 5'd0, 32'sh8000_0000);
		send_command(boae_pkg::CMD_APPEND, 5'd0, 32'sh7FFF_FFFF);
		send_command(boae_pkg::CMD_INSERT, 5'd2, -32'sd1);
		send_command(boae_pkg::CMD_INSERT, 5'd1, 32'sd0);
		send_command(boae_pkg::CMD_APPEND, 5'd31, 32'sh7FFF_FFFF);
		send_command(boae_pkg::CMD_SEARCH, 5'd0, 32'sh7FFF_FFFF);
		send_command(boae_pkg::CMD_OVERWRITE, 5'd0, 32'sh5555_5555);
		send_command(boae_pkg::CMD_READ, 5'd0, 32'sd0);
		send_command(boae_pkg::CMD_READ, 5'd4, 32'sd0);
		send_command(boae_pkg::CMD_READ, 5'd31, 32'sd0);
		send_command(boae_pkg::CMD_DELETE, 5'd1, 32'sd0);
		send_command(boae_pkg::CMD_DELETE, 5'd3, 32'sd0);
		send_command(boae_pkg::CMD_SEARCH, 5'd0, 32'sd0);
		drain_results();
		write_capacity(2);
		send_command(boae_pkg::CMD_APPEND, 5'd0, 32'sd7);
		send_command(boae_pkg::CMD_INSERT, 5'd4, 32'sd7);
		send_command(boae_pkg::CMD_INSERT, 5'd0, 32'sd7);
		send_command(boae_pkg::CMD_DELETE, 5'd0, 32'sd0);
		send_command(boae_pkg::CMD_APPEND, 5'd0, 32'sh2AAA_AAAA);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 31;
				recv_idle_pct = 84;
			end else if (ph < 6) begin
				send_idle_pct = 84;
				recv_idle_pct = 31;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_capacity(caps[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph >= 6 && k == HOLD_AT_ITEM) hold_trigger = 1'b1;
				make_command(c, p, v);
				send_command(c, p, v);
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		$display("Ran %0d commands over %0d capacity writes; %0d results checked, %0d mismatches.",
			commands_sent, capacity_writes, list_track.checked, list_track.errors);
		$display("Status mix: ok %0d, bad position %0d, full %0d, not found %0d.",
			list_track.status_seen[boae_pkg::STAT_OK],
			list_track.status_seen[boae_pkg::STAT_BAD_POS],
			list_track.status_seen[boae_pkg::STAT_FULL],
			list_track.status_seen[boae_pkg::STAT_NOT_FOUND]);
		if (list_track.errors == 0 && list_track.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
